// ----- hdl/assert_macros.svh -----
// Assertion macros shared by the descriptor manager RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is held.
`define VQ_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// Clocked implication, disabled while reset is held.
`define VQ_ASSERT_IMP(lbl, pre, post, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

// ----- hdl/vqdm_pkg.sv -----
// Types and constants of the virtqueue descriptor manager.
package vqdm_pkg;

    localparam int QUEUE_SIZE = 256;
    localparam int IDX_W      = $clog2(QUEUE_SIZE);
    localparam int CNT_W      = IDX_W + 1;

    localparam logic [1:0] FUNC_SUBMIT  = 2'd0;
    localparam logic [1:0] FUNC_USED    = 2'd1;
    localparam logic [1:0] FUNC_RELEASE = 2'd2;
    localparam logic [1:0] FUNC_BAD     = 2'd3;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_BAD_REQ  = 3'd1;
    localparam logic [2:0] ST_NO_SPACE = 3'd2;
    localparam logic [2:0] ST_DROPPED  = 3'd3;
    localparam logic [2:0] ST_BAD_USED = 3'd4;
    localparam logic [2:0] ST_REL_FAIL = 3'd5;

    localparam logic [1:0] CFG_QSIZE  = 2'd0;
    localparam logic [1:0] CFG_QNUM   = 2'd1;
    localparam logic [1:0] CFG_NOTIFY = 2'd2;

    // One descriptor entry as kept in the descriptor memory.
    typedef struct packed {
        logic [IDX_W-1:0] link;
        logic [1:0]       flags;
        logic             busy;
        logic             head;
    } t_entry;

    // One result request.
    typedef struct packed {
        logic [2:0]       status;
        logic [IDX_W-1:0] desc_index;
        logic [63:0]      desc_addr;
        logic [31:0]      desc_len;
        logic [1:0]       desc_flags;
        logic [IDX_W-1:0] desc_next;
        logic             publish;
        logic [15:0]      avail_index;
        logic [IDX_W-1:0] avail_head;
        logic             notify_out;
        logic [63:0]      cookie_out;
        logic [31:0]      done_len;
    } t_result;

endpackage

// ----- hdl/virtqueue_descriptor_manager.sv -----
// Split-virtqueue descriptor manager: free list, chain submit and chain free walk.
//
//  channel | direction | handshake                   | payload
//  in      | input     | i_in_valid / o_in_ready     | i_func .. i_release_head
//  out     | output    | o_out_valid / i_out_ready   | o_status .. o_done_len
//  cfg     | input     | i_cfg_we (no wait)          | i_cfg_index, i_cfg_data
//
// A submit element takes one descriptor memory read and one read-modify-write; a
// dropped element or a rejected request takes only the read. A completion or
// release checks the head entry, then walks the chain in the single-port memory
// with a read and a write-back per entry, and clears a longer chain's head last.
// Reset and a valid queue size write clear all per-entry valid bits at once.
// A request is taken only while the output register is empty or being drained.
module virtqueue_descriptor_manager (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  logic [1:0]                 i_func,
    input  logic [63:0]                i_buf_addr,
    input  logic [31:0]                i_buf_len,
    input  logic                       i_buf_writable,
    input  logic [8:0]                 i_chain_count,
    input  logic [63:0]                i_cookie,
    input  logic                       i_notify,
    input  logic [31:0]                i_used_id,
    input  logic [31:0]                i_used_len,
    input  logic [15:0]                i_release_head,
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output logic [2:0]                 o_status,
    output logic [vqdm_pkg::IDX_W-1:0] o_desc_index,
    output logic [63:0]                o_desc_addr,
    output logic [31:0]                o_desc_len,
    output logic [1:0]                 o_desc_flags,
    output logic [vqdm_pkg::IDX_W-1:0] o_desc_next,
    output logic                       o_publish,
    output logic [15:0]                o_avail_index,
    output logic [vqdm_pkg::IDX_W-1:0] o_avail_head,
    output logic                       o_notify_out,
    output logic [63:0]                o_cookie_out,
    output logic [31:0]                o_done_len,
    input  logic                       i_cfg_we,
    input  logic [1:0]                 i_cfg_index,
    input  logic [15:0]                i_cfg_data
);
    import vqdm_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_SUB   = 5'b00010,
        S_CHK   = 5'b00100,
        S_WALK  = 5'b01000,
        S_WSTEP = 5'b10000
    } t_state;

    t_state r_state, n_state;
    logic   r_clrh, n_clrh;

    // Configuration registers.
    logic [CNT_W-1:0] r_qsize;
    logic [15:0]      r_qnum;
    logic             r_notify_en;

    // Queue bookkeeping.
    logic [IDX_W-1:0] r_free_top, n_free_top;
    logic [CNT_W-1:0] r_free_cnt, n_free_cnt;
    logic [15:0]      r_avail, n_avail;
    logic [CNT_W-1:0] r_left, n_left;
    logic             r_drop, n_drop;
    logic [IDX_W-1:0] r_chain_first, n_chain_first;

    // Walk registers.
    logic [IDX_W-1:0] r_idx, n_idx;
    logic [IDX_W-1:0] r_head, n_head;
    logic [IDX_W-1:0] r_head_link, n_head_link;

    // Latched request.
    logic [1:0]       r_func;
    logic [63:0]      r_addr;
    logic [31:0]      r_len;
    logic             r_wr;
    logic [CNT_W-1:0] r_cc;
    logic [63:0]      r_ck_in;
    logic             r_ntf;
    logic [31:0]      r_uid;
    logic [31:0]      r_ulen;
    logic [15:0]      r_rhead;

    // Output register.
    logic    r_ov, n_ov;
    t_result r_out, n_out;

    // Memories and their valid bits.
    t_entry           mem_desc [QUEUE_SIZE];
    logic [63:0]      mem_ck   [QUEUE_SIZE];
    logic [QUEUE_SIZE-1:0] r_vld;
    t_entry           r_rd;
    logic             r_rd_vld;
    logic [IDX_W-1:0] r_rd_addr;
    logic [63:0]      r_ck_rd;

    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    logic             ck_rd_en;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    t_entry           wr_data;
    logic             ck_wr_en;

    logic             accept;
    logic             qsize_ok;
    logic             rebuild;
    t_entry           ent;
    logic [CNT_W-1:0] rd_plus1;

    // Rest of the combinational signals.
    logic             first;
    logic [CNT_W-1:0] rem;
    logic             last;
    logic             more;
    logic [31:0]      id_val;
    logic             fail_chk;

    assign accept     = i_in_valid && o_in_ready;
    assign o_in_ready = (r_state == S_IDLE) && !r_clrh && (!r_ov || i_out_ready);

    // Queue size writes must be a power of two in range.
    assign qsize_ok = (i_cfg_data[8:0] >= 9'd2) && (i_cfg_data[8:0] <= 9'(QUEUE_SIZE))
                   && ((i_cfg_data[8:0] & (i_cfg_data[8:0] - 9'd1)) == 9'd0);
    assign rebuild  = i_cfg_we && (i_cfg_index == CFG_QSIZE) && qsize_ok;

    // An entry never written reads as its reset value.
    assign rd_plus1 = {1'b0, r_rd_addr} + 9'd1;
    always_comb begin
        ent = r_rd;
        if (!r_rd_vld) begin
            ent.link  = (rd_plus1 < r_qsize) ? rd_plus1[IDX_W-1:0] : '0;
            ent.flags = 2'b00;
            ent.busy  = 1'b0;
            ent.head  = 1'b0;
        end
    end

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_qsize     <= 9'(QUEUE_SIZE);
            r_qnum      <= '0;
            r_notify_en <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_QSIZE:  if (qsize_ok) r_qsize <= i_cfg_data[8:0];
                CFG_QNUM:   r_qnum <= i_cfg_data;
                CFG_NOTIFY: r_notify_en <= i_cfg_data[0];
                default:    ;
            endcase
        end
    end

    // Memory addressing.
    always_comb begin
        rd_en    = 1'b0;
        rd_addr  = r_idx;
        ck_rd_en = 1'b0;
        if (accept) begin
            rd_en    = 1'b1;
            ck_rd_en = 1'b1;
            unique case (i_func)
                FUNC_SUBMIT:  rd_addr = r_free_top;
                FUNC_RELEASE: rd_addr = i_release_head[IDX_W-1:0];
                default:      rd_addr = i_used_id[IDX_W-1:0];
            endcase
        end else if (r_state == S_WALK) begin
            rd_en = 1'b1;
        end
    end

    // Descriptor and cookie memories.
    always_ff @(posedge i_clk) begin
        if (wr_en) mem_desc[wr_addr] <= wr_data;
        if (rd_en) begin
            r_rd      <= mem_desc[rd_addr];
            r_rd_addr <= rd_addr;
        end
        if (ck_wr_en) mem_ck[r_free_top] <= r_ck_in;
        if (ck_rd_en) r_ck_rd <= mem_ck[rd_addr];
    end

    // Per-entry valid bits, cleared at once by reset and rebuild.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || rebuild) begin
            r_vld    <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            if (rd_en) r_rd_vld <= r_vld[rd_addr] || (wr_en && wr_addr == rd_addr);
            if (wr_en) r_vld[wr_addr] <= 1'b1;
        end
    end

    // Latch the accepted request.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_func  <= i_func;
            r_addr  <= i_buf_addr;
            r_len   <= i_buf_len;
            r_wr    <= i_buf_writable;
            r_cc    <= i_chain_count;
            r_ck_in <= i_cookie;
            r_ntf   <= i_notify;
            r_uid   <= i_used_id;
            r_ulen  <= i_used_len;
            r_rhead <= i_release_head;
        end
    end

    // Sequencer: submit step, header check and chain walk.
    always_comb begin
        n_state       = r_state;
        n_clrh        = r_clrh;
        n_free_top    = r_free_top;
        n_free_cnt    = r_free_cnt;
        n_avail       = r_avail;
        n_left        = r_left;
        n_drop        = r_drop;
        n_chain_first = r_chain_first;
        n_idx         = r_idx;
        n_head        = r_head;
        n_head_link   = r_head_link;
        n_ov          = r_ov && !i_out_ready;
        n_out         = r_out;
        wr_en         = 1'b0;
        wr_addr       = r_idx;
        wr_data       = ent;
        ck_wr_en      = 1'b0;
        first         = (r_left == '0);
        rem           = first ? r_cc : r_left;
        last          = (rem == 9'd1);
        more          = ent.flags[0];
        id_val        = (r_func == FUNC_RELEASE) ? {16'd0, r_rhead} : r_uid;
        fail_chk      = 1'b0;

        // Clear the head flag after a longer walk has finished.
        if (r_clrh) begin
            wr_en   = 1'b1;
            wr_addr = r_head;
            wr_data = '{link: r_head_link, flags: 2'b00, busy: 1'b0, head: 1'b0};
            n_clrh  = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (accept) n_state = (i_func == FUNC_SUBMIT) ? S_SUB : S_CHK;
            end
            S_SUB: begin
                n_state = S_IDLE;
                n_ov    = 1'b1;
                n_out   = '0;
                if (r_left != '0 && r_drop) begin
                    n_out.status = ST_DROPPED;
                    n_left       = r_left - 9'd1;
                    n_drop       = (r_left != 9'd1);
                end else if (first && (r_cc == '0 || r_cc > r_qsize)) begin
                    n_out.status = ST_BAD_REQ;
                    n_left       = (r_cc != '0) ? r_cc - 9'd1 : '0;
                    n_drop       = (r_cc > 9'd1);
                end else if ((first && r_free_cnt < r_cc) || r_free_cnt == '0
                             || {1'b0, r_free_top} >= r_qsize || ent.busy) begin
                    n_out.status = ST_NO_SPACE;
                    n_left       = rem - 9'd1;
                    n_drop       = (rem != 9'd1);
                end else begin
                    // Pop the free list and write the descriptor.
                    wr_en         = 1'b1;
                    wr_addr       = r_free_top;
                    wr_data.busy  = 1'b1;
                    wr_data.head  = first ? 1'b1 : ent.head;
                    wr_data.flags = {r_wr, !last};
                    wr_data.link  = last ? '0 : ent.link;
                    ck_wr_en      = first;
                    n_free_top    = ent.link;
                    n_free_cnt    = r_free_cnt - 9'd1;
                    n_left        = rem - 9'd1;
                    if (first) n_chain_first = r_free_top;
                    n_out.desc_index = r_free_top;
                    n_out.desc_addr  = r_addr;
                    n_out.desc_len   = r_len;
                    n_out.desc_flags = {r_wr, !last};
                    n_out.desc_next  = last ? '0 : ent.link;
                    if (last) begin
                        n_out.publish     = 1'b1;
                        n_out.avail_index = r_avail;
                        n_out.avail_head  = first ? r_free_top : r_chain_first;
                        n_out.notify_out  = r_ntf && r_notify_en;
                        n_avail           = r_avail + 16'd1;
                    end
                end
            end
            S_CHK: begin
                n_out = '0;
                if (r_func == FUNC_BAD || (r_left != '0 && !r_drop)) begin
                    n_out.status = ST_BAD_REQ;
                    n_ov         = 1'b1;
                    n_state      = S_IDLE;
                end else begin
                    fail_chk = (id_val >= {23'd0, r_qsize}) || !ent.head || !ent.busy;
                    if (fail_chk) begin
                        n_out.status = (r_func == FUNC_USED) ? ST_BAD_USED : ST_REL_FAIL;
                        n_ov         = 1'b1;
                        n_state      = S_IDLE;
                    end else begin
                        n_idx   = id_val[IDX_W-1:0];
                        n_head  = id_val[IDX_W-1:0];
                        n_state = S_WSTEP;
                    end
                end
            end
            S_WALK: begin
                n_state = S_WSTEP;
            end
            S_WSTEP: begin
                n_out = '0;
                if ({1'b0, r_idx} >= r_qsize || !ent.busy) begin
                    n_out.status = (r_func == FUNC_USED) ? ST_BAD_USED : ST_REL_FAIL;
                    n_ov         = 1'b1;
                    n_state      = S_IDLE;
                end else begin
                    // Push this entry back onto the free list.
                    wr_en         = 1'b1;
                    wr_addr       = r_idx;
                    wr_data.link  = r_free_top;
                    wr_data.flags = 2'b00;
                    wr_data.busy  = 1'b0;
                    wr_data.head  = ent.head && !(r_idx == r_head && !more);
                    if (r_idx == r_head) n_head_link = r_free_top;
                    n_free_top = r_idx;
                    n_free_cnt = r_free_cnt + 9'd1;
                    if (more) begin
                        n_idx   = ent.link;
                        n_state = S_WALK;
                    end else begin
                        n_clrh  = (r_idx != r_head);
                        n_ov    = 1'b1;
                        n_state = S_IDLE;
                        n_out.status = ST_OK;
                        if (r_func == FUNC_USED) begin
                            n_out.cookie_out = r_ck_rd;
                            n_out.done_len   = r_ulen;
                        end
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || rebuild) begin
            r_state       <= S_IDLE;
            r_clrh        <= 1'b0;
            r_free_top    <= '0;
            r_free_cnt    <= !i_rst_n ? 9'(QUEUE_SIZE) : i_cfg_data[8:0];
            r_avail       <= '0;
            r_left        <= '0;
            r_drop        <= 1'b0;
            r_chain_first <= '0;
            r_ov          <= 1'b0;
        end else begin
            r_state       <= n_state;
            r_clrh        <= n_clrh;
            r_free_top    <= n_free_top;
            r_free_cnt    <= n_free_cnt;
            r_avail       <= n_avail;
            r_left        <= n_left;
            r_drop        <= n_drop;
            r_chain_first <= n_chain_first;
            r_ov          <= n_ov;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_idx       <= n_idx;
        r_head      <= n_head;
        r_head_link <= n_head_link;
        r_out       <= n_out;
    end

    assign o_out_valid   = r_ov;
    assign o_status      = r_out.status;
    assign o_desc_index  = r_out.desc_index;
    assign o_desc_addr   = r_out.desc_addr;
    assign o_desc_len    = r_out.desc_len;
    assign o_desc_flags  = r_out.desc_flags;
    assign o_desc_next   = r_out.desc_next;
    assign o_publish     = r_out.publish;
    assign o_avail_index = r_out.avail_index;
    assign o_avail_head  = r_out.avail_head;
    assign o_notify_out  = r_out.notify_out;
    assign o_cookie_out  = r_out.cookie_out;
    assign o_done_len    = r_out.done_len;

    // The queue number register is not used by the logic; it is reduced into an unused signal here.
    logic unused_qnum;
    assign unused_qnum = ^r_qnum;

`include "assert_macros.svh"

    // The free count never exceeds the active queue size.
    `VQ_ASSERT(a_free_cnt, r_free_cnt <= r_qsize, "free count above queue size")
    // An accepted request always leaves the idle state.
    `VQ_ASSERT_IMP(a_accept_busy, accept && !rebuild, r_state != S_IDLE, "request not started")
    // A new result only appears after a working state.
    `VQ_ASSERT(a_out_src, $rose(o_out_valid) |-> $past(r_state) != S_IDLE,
        "result raised from idle")

endmodule
